@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/ebm_pkg.sv @@
package ebm_pkg;

   localparam int Q_W     = 32;
   localparam int SCALE_W = 31;
   localparam int ROW_W   = SCALE_W + 4 * Q_W;

   // request tdata layout, lowest bit first
   localparam int DIM_LSB   = 0;
   localparam int COORD_LSB = 3;
   localparam int FA_LSB    = 35;
   localparam int FB_LSB    = 67;
   localparam int LO_LSB    = 99;
   localparam int HI_LSB    = 131;
   localparam int SCALE_LSB = 163;
   localparam int REQ_DATA_W = 200;
   localparam int RSP_DATA_W = 8;

   localparam int SQRT_STEPS = 32;
   localparam int CNT_W      = 5;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_POINT = 1'b1;

   localparam logic REG_COST_LIMIT = 1'b0;
   localparam logic REG_COST_INF   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LD_MUL,
      ST_LD_DRAIN,
      ST_LD_WR,
      ST_PT_SCALE,
      ST_PT_Q,
      ST_PT_MAG,
      ST_PT_SQA,
      ST_PT_SQB,
      ST_PT_ACC,
      ST_SQ_INIT,
      ST_SQ_RUN,
      ST_DONE
   } ebm_state_type;

   // multiplier operand select; the product is routed by the same tag in the next cycle
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_FA,
      MUL_FB,
      MUL_LO,
      MUL_HI,
      MUL_COORD,
      MUL_SQA,
      MUL_SQB
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      mul_sel_type mul_sel;
      logic        mag_en;
      logic        ram_wr;
      logic        sq_init;
      logic        sq_step;
      logic        out_load;
   } ebm_cmd_type;

   typedef struct packed {
      logic opcode;
      logic last;
      logic dim_ok;
      logic out_free;
   } ebm_status_type;

endpackage

@@ rtl/core/ebm_ram.sv @@
module ebm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ebm_ctrl.sv @@
module ebm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  ebm_pkg::ebm_status_type status,
   output ebm_pkg::ebm_cmd_type    cmd
);

   ebm_pkg::ebm_state_type state_ff, state_in;
   logic [ebm_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ebm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.mul_sel  = ebm_pkg::MUL_NONE;
      case (state_ff)
         ebm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ebm_pkg::ST_DECODE;
            end
         end
         ebm_pkg::ST_DECODE: begin
            // row read is in flight during this cycle
            if (status.opcode == ebm_pkg::OP_LOAD) begin
               cnt_in   = '0;
               state_in = status.dim_ok ? ebm_pkg::ST_LD_MUL : ebm_pkg::ST_IDLE;
            end else if (status.dim_ok) begin
               state_in = ebm_pkg::ST_PT_SCALE;
            end else begin
               state_in = status.last ? ebm_pkg::ST_SQ_INIT : ebm_pkg::ST_IDLE;
            end
         end
         ebm_pkg::ST_LD_MUL: begin
            case (cnt_ff[1:0])
               2'd0:    cmd.mul_sel = ebm_pkg::MUL_FA;
               2'd1:    cmd.mul_sel = ebm_pkg::MUL_FB;
               2'd2:    cmd.mul_sel = ebm_pkg::MUL_LO;
               default: cmd.mul_sel = ebm_pkg::MUL_HI;
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = ebm_pkg::ST_LD_DRAIN;
            end
         end
         ebm_pkg::ST_LD_DRAIN: begin
            state_in = ebm_pkg::ST_LD_WR;
         end
         ebm_pkg::ST_LD_WR: begin
            cmd.ram_wr = 1'b1;
            state_in   = ebm_pkg::ST_IDLE;
         end
         ebm_pkg::ST_PT_SCALE: begin
            cmd.mul_sel = ebm_pkg::MUL_COORD;
            state_in    = ebm_pkg::ST_PT_Q;
         end
         ebm_pkg::ST_PT_Q: begin
            state_in = ebm_pkg::ST_PT_MAG;
         end
         ebm_pkg::ST_PT_MAG: begin
            cmd.mag_en = 1'b1;
            state_in   = ebm_pkg::ST_PT_SQA;
         end
         ebm_pkg::ST_PT_SQA: begin
            cmd.mul_sel = ebm_pkg::MUL_SQA;
            state_in    = ebm_pkg::ST_PT_SQB;
         end
         ebm_pkg::ST_PT_SQB: begin
            cmd.mul_sel = ebm_pkg::MUL_SQB;
            state_in    = ebm_pkg::ST_PT_ACC;
         end
         ebm_pkg::ST_PT_ACC: begin
            state_in = status.last ? ebm_pkg::ST_SQ_INIT : ebm_pkg::ST_IDLE;
         end
         ebm_pkg::ST_SQ_INIT: begin
            cmd.sq_init = 1'b1;
            cnt_in      = '0;
            state_in    = ebm_pkg::ST_SQ_RUN;
         end
         ebm_pkg::ST_SQ_RUN: begin
            cmd.sq_step = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == ebm_pkg::CNT_W'(ebm_pkg::SQRT_STEPS - 1)) begin
               state_in = ebm_pkg::ST_DONE;
            end
         end
         ebm_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ebm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ebm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/ebm_dp.sv @@
module ebm_dp #(
   parameter int MAX_DIMS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ebm_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ebm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [ebm_pkg::Q_W-1:0]           csr_wr_data,
   input  ebm_pkg::ebm_cmd_type              cmd,
   output ebm_pkg::ebm_status_type           status
);

   localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int QW = ebm_pkg::Q_W;
   localparam int SW = ebm_pkg::SCALE_W;

   // captured item
   logic [2:0]           dim_ff;
   logic                 op_ff;
   logic                 last_ff;
   logic signed [QW-1:0] coord_ff, fa_raw_ff, fb_raw_ff, lo_raw_ff, hi_raw_ff;
   logic [SW-1:0]        scale_ff;

   // scaled row under construction, scaled coordinate, magnitudes
   logic signed [QW-1:0] fa_s_ff, fb_s_ff, lo_s_ff, hi_s_ff, q_ff;
   logic [QW-1:0]        mag_a_ff, mag_b_ff;

   logic signed [63:0]   prod_ff;
   ebm_pkg::mul_sel_type tag_ff;

   logic [63:0] acc_a_ff, acc_b_ff;
   logic        box_ff;

   logic [63:0] bit_ff, xa_ff, ra_ff, xb_ff, rb_ff;

   logic [QW-1:0] cost_limit_ff;
   logic          cost_inf_ff;

   logic rsp_valid_ff, in_set_ff, box_ok_ff;

   logic [ebm_pkg::ROW_W-1:0] row_rd, row_wr;
   logic [SW-1:0]        row_scale;
   logic signed [QW-1:0] row_fa, row_fb, row_lo, row_hi;
   logic [DIM_W-1:0]     addr;

   logic signed [32:0] op_a, op_b;
   logic signed [65:0] prod_full;
   logic signed [63:0] prod_shr;
   logic signed [QW-1:0] qm;

   logic signed [32:0] diff_a, diff_b;
   logic signed [QW-1:0] dsat_a, dsat_b;
   logic [64:0] sum_acc;
   logic [63:0] ta, tb;
   logic [32:0] focal_sum;
   logic        dim_ok;

   function automatic logic signed [QW-1:0] sat33(input logic signed [32:0] v);
      logic signed [QW-1:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [QW-1:0] mag32(input logic signed [QW-1:0] v);
      logic signed [32:0] w;
      w = {v[31], v};
      if (v[31]) begin
         w = -w;
      end
      return w[31:0];
   endfunction

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dim_ff    <= req_tdata[ebm_pkg::DIM_LSB +: 3];
         op_ff     <= req_tuser;
         last_ff   <= req_tlast;
         coord_ff  <= req_tdata[ebm_pkg::COORD_LSB +: QW];
         fa_raw_ff <= req_tdata[ebm_pkg::FA_LSB +: QW];
         fb_raw_ff <= req_tdata[ebm_pkg::FB_LSB +: QW];
         lo_raw_ff <= req_tdata[ebm_pkg::LO_LSB +: QW];
         hi_raw_ff <= req_tdata[ebm_pkg::HI_LSB +: QW];
         scale_ff  <= req_tdata[ebm_pkg::SCALE_LSB +: SW];
      end
   end

   assign dim_ok = ({29'd0, dim_ff} < 32'(MAX_DIMS));
   assign addr   = DIM_W'(dim_ff);
   assign row_wr = {scale_ff, hi_s_ff, lo_s_ff, fb_s_ff, fa_s_ff};

   ebm_ram #(
      .WIDTH (ebm_pkg::ROW_W),
      .DEPTH (MAX_DIMS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (cmd.ram_wr),
      .wr_addr (addr),
      .wr_data (row_wr),
      .rd_addr (addr),
      .rd_data (row_rd)
   );

   assign row_fa    = row_rd[0 +: QW];
   assign row_fb    = row_rd[QW +: QW];
   assign row_lo    = row_rd[2*QW +: QW];
   assign row_hi    = row_rd[3*QW +: QW];
   assign row_scale = row_rd[4*QW +: SW];

   // shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         ebm_pkg::MUL_FA: begin
            op_a = {fa_raw_ff[31], fa_raw_ff};
            op_b = {2'b00, scale_ff};
         end
         ebm_pkg::MUL_FB: begin
            op_a = {fb_raw_ff[31], fb_raw_ff};
            op_b = {2'b00, scale_ff};
         end
         ebm_pkg::MUL_LO: begin
            op_a = {lo_raw_ff[31], lo_raw_ff};
            op_b = {2'b00, scale_ff};
         end
         ebm_pkg::MUL_HI: begin
            op_a = {hi_raw_ff[31], hi_raw_ff};
            op_b = {2'b00, scale_ff};
         end
         ebm_pkg::MUL_COORD: begin
            op_a = {coord_ff[31], coord_ff};
            op_b = {2'b00, row_scale};
         end
         ebm_pkg::MUL_SQA: begin
            op_a = {1'b0, mag_a_ff};
            op_b = {1'b0, mag_a_ff};
         end
         ebm_pkg::MUL_SQB: begin
            op_a = {1'b0, mag_b_ff};
            op_b = {1'b0, mag_b_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_full = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_full[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= ebm_pkg::MUL_NONE;
      end else begin
         tag_ff <= cmd.mul_sel;
      end
   end

   // Q16.16 product: arithmetic shift floors, then clamp to 32 bits
   always_comb begin
      prod_shr = prod_ff >>> 16;
      if (prod_shr > 64'sd2147483647) begin
         qm = {1'b0, {(QW-1){1'b1}}};
      end else if (prod_shr < -64'sd2147483648) begin
         qm = {1'b1, {(QW-1){1'b0}}};
      end else begin
         qm = prod_shr[31:0];
      end
   end

   always_ff @(posedge clock) begin
      case (tag_ff)
         ebm_pkg::MUL_FA:    fa_s_ff <= qm;
         ebm_pkg::MUL_FB:    fb_s_ff <= qm;
         ebm_pkg::MUL_LO:    lo_s_ff <= qm;
         ebm_pkg::MUL_HI:    hi_s_ff <= qm;
         ebm_pkg::MUL_COORD: q_ff    <= qm;
         default: ;
      endcase
   end

   // focal differences
   assign diff_a = {q_ff[31], q_ff} - {row_fa[31], row_fa};
   assign diff_b = {q_ff[31], q_ff} - {row_fb[31], row_fb};
   assign dsat_a = sat33(diff_a);
   assign dsat_b = sat33(diff_b);

   always_ff @(posedge clock) begin
      if (cmd.mag_en) begin
         mag_a_ff <= mag32(dsat_a);
         mag_b_ff <= mag32(dsat_b);
      end
   end

   // accumulators and box flag
   always_comb begin
      if (tag_ff == ebm_pkg::MUL_SQB) begin
         sum_acc = {1'b0, acc_b_ff} + {1'b0, prod_ff};
      end else begin
         sum_acc = {1'b0, acc_a_ff} + {1'b0, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_a_ff <= '0;
         acc_b_ff <= '0;
         box_ff   <= 1'b1;
      end else if (cmd.out_load) begin
         acc_a_ff <= '0;
         acc_b_ff <= '0;
         box_ff   <= 1'b1;
      end else begin
         if (tag_ff == ebm_pkg::MUL_SQA) begin
            acc_a_ff <= sum_acc[64] ? '1 : sum_acc[63:0];
         end
         if (tag_ff == ebm_pkg::MUL_SQB) begin
            acc_b_ff <= sum_acc[64] ? '1 : sum_acc[63:0];
         end
         if (cmd.mag_en && (q_ff > row_hi || q_ff < row_lo)) begin
            box_ff <= 1'b0;
         end
      end
   end

   // two bit-pair square roots in lockstep, one result bit per cycle
   assign ta = ra_ff + bit_ff;
   assign tb = rb_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.sq_init) begin
         bit_ff <= 64'd1 << 62;
         xa_ff  <= acc_a_ff;
         xb_ff  <= acc_b_ff;
         ra_ff  <= '0;
         rb_ff  <= '0;
      end else if (cmd.sq_step) begin
         bit_ff <= bit_ff >> 2;
         if (xa_ff >= ta) begin
            xa_ff <= xa_ff - ta;
            ra_ff <= (ra_ff >> 1) + bit_ff;
         end else begin
            ra_ff <= ra_ff >> 1;
         end
         if (xb_ff >= tb) begin
            xb_ff <= xb_ff - tb;
            rb_ff <= (rb_ff >> 1) + bit_ff;
         end else begin
            rb_ff <= rb_ff >> 1;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cost_limit_ff <= '0;
         cost_inf_ff   <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            ebm_pkg::REG_COST_LIMIT: cost_limit_ff <= csr_wr_data;
            ebm_pkg::REG_COST_INF:   cost_inf_ff   <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // output register
   assign focal_sum = {1'b0, ra_ff[31:0]} + {1'b0, rb_ff[31:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         box_ok_ff <= box_ff;
         in_set_ff <= box_ff && (cost_inf_ff || (focal_sum < {1'b0, cost_limit_ff}));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ebm_pkg::RSP_DATA_W-2){1'b0}}, box_ok_ff, in_set_ff};

   assign status.opcode   = op_ff;
   assign status.last     = last_ff;
   assign status.dim_ok   = dim_ok;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

endmodule

@@ rtl/core/ellipsoid_box_membership_test.sv @@
// Box and prolate-hyperspheroid membership test, Q16.16 fixed point.
// req channel: tuser = opcode (0 loads a dimension row, 1 brings one point
// coordinate), tlast = last coordinate of the point, tdata = row/coordinate.
// rsp channel: one item per point, sent after its last coordinate.
// csr port: index 0 = cost limit, index 1 = cost-infinite flag; write only
// while the block is idle.
// Sequencing: a load item or a point coordinate is finished before the
// next item is accepted; the single shared 33x33 multiplier is used once
// per scaled value and once per squared distance. A last coordinate also
// starts the two square roots, which run in lockstep producing one result
// bit per cycle; rsp_tvalid rises once they finish and the output
// register is free.
// The result sits in an output register: if rsp stalls, the block keeps
// taking items and only waits when a second result is ready to go out.
// Reset (synchronous): clears accumulators, sets the box flag, cost limit 0,
// cost infinite; the row memory is undefined until each row is loaded.
`include "assert_macros.svh"

module ellipsoid_box_membership_test #(
   parameter int MAX_DIMS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // dim_index[2:0], coord[34:3], focus_a_raw[66:35], focus_b_raw[98:67],
   // lower_raw[130:99], upper_raw[162:131], scale_value[193:163], zero pad
   input  logic [ebm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,   // opcode
   input  logic                           req_tlast,   // last_coord
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ebm_pkg::RSP_DATA_W-1:0] rsp_tdata,   // in_set[0], box_ok[1], zero pad
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [ebm_pkg::Q_W-1:0]        csr_wr_data
);

   ebm_pkg::ebm_cmd_type    cmd;
   ebm_pkg::ebm_status_type status;

   ebm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ebm_dp #(
      .MAX_DIMS (MAX_DIMS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

   // a new result never overwrites one still waiting
   `ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.out_load, status.out_free)
   // an accepted item holds off the next one
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   // a result only appears after the controller loads it
   `ASSERT_IMPLY(a_rsp_from_load, clock, reset, $rose(rsp_tvalid), $past(cmd.out_load))

endmodule
